### sv/sbmd_pkg.sv
// Package with the phase and status codes of the seven-bit message deframer.
`timescale 1ns / 1ps

package sbmd_pkg;

  // Number of payload bytes that are kept; further bytes are checked and dropped.
  localparam int unsigned PayloadSlots = 4;

  // Bit layout of a received byte.
  localparam logic [7:0] HighBitMask = 8'b1000_0000;
  localparam logic [7:0] LowBitsMask = 8'b0111_1111;

  // Output tdata width: status, type, size and four data bytes, padded to bytes.
  localparam int unsigned OutFieldBits = 3 + 7 + 3 + 8 * PayloadSlots;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  // Parser phase.
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhType = 2'd1,
    PhSize = 2'd2,
    PhData = 2'd3
  } phase_e;

  // Status reported for every byte.
  typedef enum logic [2:0] {
    StIgnored = 3'd0,
    StAgain   = 3'd1,
    StDone    = 3'd2,
    StBadType = 3'd3,
    StBadSize = 3'd4,
    StBadData = 3'd5
  } status_e;

  // One result item.
  typedef struct packed {
    logic [7:0] data_3;
    logic [7:0] data_2;
    logic [7:0] data_1;
    logic [7:0] data_0;
    logic [2:0] msg_size;
    logic [6:0] msg_type;
    status_e    status;
  } result_t;

endpackage

### sv/seven_bit_message_deframer.sv
// Top level of the seven-bit message deframer: byte parser and result register.
// Latency: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the result
// register is the only stage between the two stream sides.
// Reset: asynchronous active-low reset returns the parser to idle, clears held
// type, size, count and payload, and empties the result register.
`timescale 1ns / 1ps

module seven_bit_message_deframer
  import sbmd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] status, [9:3] msg_type, [12:10] msg_size, [20:13] data_0,
  // [28:21] data_1, [36:29] data_2, [44:37] data_3, rest zero
  output logic [OutDataBits-1:0] m_axis_tdata
);

  phase_e     phase_q, phase_d;
  logic [6:0] held_type_q, held_type_d;
  logic [2:0] held_size_q, held_size_d;
  logic [2:0] byte_count_q, byte_count_d;
  logic [7:0] payload_q [PayloadSlots];
  logic [7:0] payload_d [PayloadSlots];

  logic       out_valid_q;
  result_t    result_q, result_d;
  logic       in_fire;
  logic       high_bit;

  // A new request is taken whenever the result register is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign high_bit      = (s_axis_tdata & HighBitMask) != 8'd0;

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      held_type_q  <= 7'd0;
      held_size_q  <= 3'd0;
      byte_count_q <= 3'd0;
      for (int k = 0; k < PayloadSlots; k++) begin
        payload_q[k] <= 8'd0;
      end
    end else if (in_fire) begin
      phase_q      <= phase_d;
      held_type_q  <= held_type_d;
      held_size_q  <= held_size_d;
      byte_count_q <= byte_count_d;
      for (int k = 0; k < PayloadSlots; k++) begin
        payload_q[k] <= payload_d[k];
      end
    end
  end

  // Next parser state and the result for the byte on the input.
  always_comb begin
    logic done;
    logic [2:0] count_inc;

    done         = 1'b0;
    count_inc    = byte_count_q + 3'd1;
    phase_d      = phase_q;
    held_type_d  = held_type_q;
    held_size_d  = held_size_q;
    byte_count_d = byte_count_q;
    for (int k = 0; k < PayloadSlots; k++) begin
      payload_d[k] = payload_q[k];
    end
    result_d = '0;

    unique case (phase_q)
      PhIdle, PhType: begin
        if (!high_bit) begin
          // Outside a message a plain byte is skipped; after a message it is an error.
          result_d.status = (phase_q == PhIdle) ? StIgnored : StBadType;
          phase_d         = PhIdle;
        end else begin
          held_type_d     = s_axis_tdata[6:0] & LowBitsMask[6:0];
          phase_d         = PhSize;
          result_d.status = StAgain;
        end
      end
      PhSize: begin
        if (high_bit) begin
          phase_d         = PhIdle;
          result_d.status = StBadSize;
        end else begin
          held_size_d  = s_axis_tdata[6:4];
          byte_count_d = 3'd0;
          // Bits 3..0 carry bit 7 of payload bytes 0..3.
          for (int k = 0; k < PayloadSlots; k++) begin
            payload_d[k] = {s_axis_tdata[3-k], 7'd0};
          end
          if (s_axis_tdata[6:4] == 3'd0) begin
            phase_d = PhType;
            done    = 1'b1;
          end else begin
            phase_d         = PhData;
            result_d.status = StAgain;
          end
        end
      end
      PhData: begin
        if (high_bit) begin
          phase_d         = PhIdle;
          result_d.status = StBadData;
        end else begin
          // Bytes past the kept slots are consumed without storing them.
          if (byte_count_q < 3'(PayloadSlots)) begin
            payload_d[byte_count_q[1:0]] = payload_q[byte_count_q[1:0]] | s_axis_tdata;
          end
          byte_count_d = count_inc;
          if (count_inc == held_size_q) begin
            phase_d = PhType;
            done    = 1'b1;
          end else begin
            result_d.status = StAgain;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // A complete message shows type, size and the bytes below the count.
    if (done) begin
      result_d.status   = StDone;
      result_d.msg_type = held_type_d;
      result_d.msg_size = held_size_d;
      result_d.data_0   = (held_size_d > 3'd0) ? payload_d[0] : 8'd0;
      result_d.data_1   = (held_size_d > 3'd1) ? payload_d[1] : 8'd0;
      result_d.data_2   = (held_size_d > 3'd2) ? payload_d[2] : 8'd0;
      result_d.data_3   = (held_size_d > 3'd3) ? payload_d[3] : 8'd0;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataBits - OutFieldBits){1'b0}}, result_q};

endmodule
